[design/sct_pkg.sv]
// Shared types and constants for the shell command tokenizer.
// No dependencies; imported by every module of the block.
package sct_pkg;

	// Result queue depth between front and back; must be a power of two.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_ESCAPE  = 2'd1;
	localparam logic [1:0] ERR_UNQUOTE = 2'd2;

	// One result item as it leaves the block (run_last added by the back end).
	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       tend;
		logic       lend;
		logic [1:0] err;
	} result_t;

	// All results of one input character; two marks a second result in r1.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

endpackage

[design/sct_front.sv]
// Front end: accepts characters, runs the lexer mode machine and packs
// each character's results into one queue entry. Depends on sct_pkg.
module sct_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_char,
	input  logic            end_of_input,
	output logic            push_valid,
	input  logic            push_ready,
	output sct_pkg::entry_t push_entry
);
	import sct_pkg::*;

	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_WORD    = 3'd1;
	localparam logic [2:0] M_PIPE    = 3'd2;
	localparam logic [2:0] M_AMP     = 3'd3;
	localparam logic [2:0] M_GT      = 3'd4;
	localparam logic [2:0] M_QUOTE   = 3'd5;
	localparam logic [2:0] M_ESC     = 3'd6;
	localparam logic [2:0] M_COMMENT = 3'd7;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef struct packed {
		logic       emit;
		result_t    res;
		logic [2:0] mode;
	} start_t;

	function automatic result_t mk(logic [7:0] ch, logic v, logic te, logic le,
		logic [1:0] err);
		result_t r;
		r.ch    = ch;
		r.valid = v;
		r.tend  = te;
		r.lend  = le;
		r.err   = err;
		return r;
	endfunction

	// First character seen while no token is open.
	function automatic start_t start_tok(logic [7:0] c);
		start_t s;
		s.emit = 1'b0;
		s.res  = mk(8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE);
		s.mode = M_IDLE;
		priority if (c == CH_SEMI || c == CH_LPAR || c == CH_RPAR || c == CH_LT) begin
			s.emit = 1'b1;
			s.res  = mk(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
		end else if (c == CH_PIPE) begin
			s.emit = 1'b1;
			s.res  = mk(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			s.mode = M_PIPE;
		end else if (c == CH_AMP) begin
			s.emit = 1'b1;
			s.res  = mk(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			s.mode = M_AMP;
		end else if (c == CH_GT) begin
			s.emit = 1'b1;
			s.res  = mk(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			s.mode = M_GT;
		end else if (c == CH_QUOTE) begin
			s.mode = M_QUOTE;
		end else if (c == CH_BSL) begin
			s.mode = M_ESC;
		end else if (c == CH_SPACE || c == CH_TAB) begin
			s.mode = M_IDLE;
		end else if (c == CH_HASH) begin
			s.mode = M_COMMENT;
		end else begin
			s.emit = 1'b1;
			s.res  = mk(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			s.mode = M_WORD;
		end
		return s;
	endfunction

	logic [2:0] mode_q;
	logic [2:0] mode_d;
	logic       eol;
	logic       delim;
	logic [7:0] op;
	logic       n_any;
	start_t     st;
	entry_t     e;
	logic       accept;

	assign eol   = end_of_input || (in_char == CH_NL);
	assign delim = in_char == CH_SEMI || in_char == CH_LPAR || in_char == CH_RPAR ||
		in_char == CH_LT || in_char == CH_PIPE || in_char == CH_AMP ||
		in_char == CH_GT || in_char == CH_SPACE || in_char == CH_TAB ||
		in_char == CH_HASH;
	assign op    = (mode_q == M_PIPE) ? CH_PIPE : (mode_q == M_AMP) ? CH_AMP : CH_GT;
	assign st    = start_tok(in_char);

	always_comb begin
		e      = '0;
		n_any  = 1'b0;
		mode_d = mode_q;
		unique case (mode_q)
			M_IDLE: begin
				if (eol) begin
					e.r0  = mk(8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
					n_any = 1'b1;
				end else begin
					e.r0   = st.res;
					n_any  = st.emit;
					mode_d = st.mode;
				end
			end
			M_WORD: begin
				if (eol) begin
					e.r0   = mk(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
					n_any  = 1'b1;
					mode_d = M_IDLE;
				end else if (in_char == CH_QUOTE) begin
					mode_d = M_QUOTE;
				end else if (in_char == CH_BSL) begin
					mode_d = M_ESC;
				end else if (delim) begin
					e.r0   = mk(8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
					e.r1   = st.res;
					e.two  = st.emit;
					n_any  = 1'b1;
					mode_d = st.mode;
				end else begin
					e.r0  = mk(in_char, 1'b1, 1'b0, 1'b0, ERR_NONE);
					n_any = 1'b1;
				end
			end
			M_PIPE, M_AMP, M_GT: begin
				n_any = 1'b1;
				if (eol) begin
					e.r0   = mk(8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
					mode_d = M_IDLE;
				end else if (in_char == op) begin
					e.r0   = mk(in_char, 1'b1, 1'b1, 1'b0, ERR_NONE);
					mode_d = M_IDLE;
				end else begin
					e.r0   = mk(8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
					e.r1   = st.res;
					e.two  = st.emit;
					mode_d = st.mode;
				end
			end
			M_QUOTE: begin
				if (eol) begin
					e.r0   = mk(8'd0, 1'b0, 1'b0, 1'b1, ERR_UNQUOTE);
					n_any  = 1'b1;
					mode_d = M_IDLE;
				end else if (in_char == CH_QUOTE) begin
					mode_d = M_WORD;
				end else begin
					e.r0  = mk(in_char, 1'b1, 1'b0, 1'b0, ERR_NONE);
					n_any = 1'b1;
				end
			end
			M_ESC: begin
				n_any = 1'b1;
				if (eol || in_char == CH_HASH) begin
					e.r0   = mk(8'd0, 1'b0, 1'b0, 1'b1, ERR_ESCAPE);
					mode_d = M_IDLE;
				end else begin
					e.r0   = mk(in_char, 1'b1, 1'b0, 1'b0, ERR_NONE);
					mode_d = M_WORD;
				end
			end
			M_COMMENT: begin
				if (eol) begin
					e.r0   = mk(8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
					n_any  = 1'b1;
					mode_d = M_IDLE;
				end
			end
		endcase
	end

	// Silent characters are taken only when the queue has room too, so the
	// front never outruns the back by more than the queue.
	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid && n_any;
	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule

[design/sct_queue.sv]
// Short entry queue between lexer front end and output back end.
// Flop-based FIFO of QDEPTH entries. Depends on sct_pkg.
module sct_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sct_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sct_pkg::entry_t pop_entry
);
	import sct_pkg::*;

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

[design/sct_back.sv]
// Back end: unpacks queue entries into single result requests and holds
// them in the output register. Depends on sct_pkg.
module sct_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  sct_pkg::entry_t pop_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_char,
	output logic            char_valid,
	output logic            token_end,
	output logic            line_end,
	output logic [1:0]      error_code,
	output logic            run_last
);
	import sct_pkg::*;

	logic    valid_q;
	result_t res_q;
	logic    last_q;
	logic    pend_q;
	result_t second_q;
	logic    load;

	assign load      = !valid_q || out_ready;
	assign pop_ready = load && !pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= pop_valid;
				pend_q  <= pop_valid && pop_entry.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				res_q  <= second_q;
				last_q <= 1'b1;
			end else if (pop_valid) begin
				res_q    <= pop_entry.r0;
				last_q   <= !pop_entry.two;
				second_q <= pop_entry.r1;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_char   = res_q.ch;
	assign char_valid = res_q.valid;
	assign token_end  = res_q.tend;
	assign line_end   = res_q.lend;
	assign error_code = res_q.err;
	assign run_last   = last_q;

endmodule

[design/shell_command_tokenizer_unit.sv]
// Shell command tokenizer: one character per request in, token results out.
// The first result of a character passes through the queue and then the output register.
// Takes one character per cycle while the queue has room; a character with two results holds the
// output for both, absorbed by the QDEPTH-entry queue behind the lexer.
// Reset (arst_n low, async): lexer idle between tokens, queue and output empty.
module shell_command_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       token_end,
	output logic       line_end,
	output logic [1:0] error_code,
	output logic       run_last
);
	import sct_pkg::*;

	// Front to queue: one entry per character that yields any result.
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;

	// Queue to back end.
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	// Mode machine and classification; silent characters only move the mode.
	sct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.end_of_input(end_of_input),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	// Decouples the lexer from output stalls.
	sct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	// Serializes one or two results per entry into the output register.
	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.char_valid(char_valid),
		.token_end (token_end),
		.line_end  (line_end),
		.error_code(error_code),
		.run_last  (run_last)
	);

endmodule

[design/sct_checker.sv]
// Port-level checks for the shell command tokenizer, bound to the top level.
// Depends on sct_pkg and shell_command_tokenizer_unit.
module sct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       token_end,
	input logic       line_end,
	input logic [1:0] error_code,
	input logic       run_last
);
	import sct_pkg::*;

	// Error results end the line and carry nothing else.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> line_end && !char_valid && !token_end)
		else $error("error result with token content");

	// A line end is always the final result of its character.
	a_lend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> run_last)
		else $error("line end not last result");

	// Results without a character carry a zero byte.
	a_empty_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> out_char == 8'd0)
		else $error("empty result with nonzero char");

	// Stalled request holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last))
		else $error("output changed while stalled");

endmodule

bind shell_command_tokenizer_unit sct_checker u_sct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_char  (out_char),
	.char_valid(char_valid),
	.token_end (token_end),
	.line_end  (line_end),
	.error_code(error_code),
	.run_last  (run_last)
);

[dv/sct_token_checker.sv]
// Scoreboard for the shell command tokenizer: predicts token results per request, checks outputs.
// Depends on sct_pkg (error codes). Watches both channels from outside the block.
`timescale 1ns / 1ps

module sct_token_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_input,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_char,
	input  logic       char_valid,
	input  logic       token_end,
	input  logic       line_end,
	input  logic [1:0] error_code,
	input  logic       run_last,
	output int         fail_count,
	output int         pending,
	output int         results_checked,
	output int         lines_checked,
	output int         errors_checked
);
	import sct_pkg::*;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PIPE   = 8'h7C;

	typedef enum logic [2:0] {
		LX_IDLE, LX_WORD, LX_PIPE, LX_AMP, LX_GT, LX_QUOTE, LX_ESC, LX_COMMENT
	} lex_mode_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       tend;
		logic       lend;
		logic [1:0] err;
		logic       last;
	} tok_result_t;

	lex_mode_e   lex_mode;
	tok_result_t step_res[$];
	tok_result_t tok_expect_q[$];

	function automatic bool_single(input logic [7:0] c);
		return c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN || c == CH_LT;
	endfunction

	function automatic void emit(input logic [7:0] ch, input logic valid, input logic tend,
			input logic lend, input logic [1:0] err);
		step_res.push_back('{ch, valid, tend, lend, err, 1'b0});
	endfunction

	// first character seen while no token is open
	function automatic void open_token(input logic [7:0] c);
		if (bool_single(c)) begin
			emit(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
			lex_mode = LX_IDLE;
		end else if (c == CH_PIPE) begin
			emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			lex_mode = LX_PIPE;
		end else if (c == CH_AMP) begin
			emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			lex_mode = LX_AMP;
		end else if (c == CH_GT) begin
			emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			lex_mode = LX_GT;
		end else if (c == CH_QUOTE) begin
			lex_mode = LX_QUOTE;
		end else if (c == CH_BSLASH) begin
			lex_mode = LX_ESC;
		end else if (c == CH_SPACE || c == CH_TAB) begin
			lex_mode = LX_IDLE;
		end else if (c == CH_HASH) begin
			lex_mode = LX_COMMENT;
		end else begin
			emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
			lex_mode = LX_WORD;
		end
	endfunction

	function automatic void lex_char(input logic [7:0] c, input logic eoi);
		logic        eol;
		logic [7:0]  op;
		tok_result_t r;
		eol = eoi || c == CH_NL;
		step_res.delete();
		case (lex_mode)
			LX_IDLE: begin
				if (eol) emit(8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
				else open_token(c);
			end
			LX_WORD: begin
				if (eol) begin
					emit(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
					lex_mode = LX_IDLE;
				end else if (c == CH_QUOTE) begin
					lex_mode = LX_QUOTE;
				end else if (c == CH_BSLASH) begin
					lex_mode = LX_ESC;
				end else if (bool_single(c) || c == CH_PIPE || c == CH_AMP || c == CH_GT ||
						c == CH_SPACE || c == CH_TAB || c == CH_HASH) begin
					emit(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
					open_token(c);
				end else begin
					emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
				end
			end
			LX_PIPE, LX_AMP, LX_GT: begin
				op = (lex_mode == LX_PIPE) ? CH_PIPE : (lex_mode == LX_AMP) ? CH_AMP : CH_GT;
				if (eol) begin
					emit(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
					lex_mode = LX_IDLE;
				end else if (c == op) begin
					emit(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
					lex_mode = LX_IDLE;
				end else begin
					emit(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
					open_token(c);
				end
			end
			LX_QUOTE: begin
				if (eol) begin
					emit(8'h00, 1'b0, 1'b0, 1'b1, ERR_UNQUOTE);
					lex_mode = LX_IDLE;
				end else if (c == CH_QUOTE) begin
					lex_mode = LX_WORD;
				end else begin
					emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
				end
			end
			LX_ESC: begin
				if (eol || c == CH_HASH) begin
					emit(8'h00, 1'b0, 1'b0, 1'b1, ERR_ESCAPE);
					lex_mode = LX_IDLE;
				end else begin
					emit(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
					lex_mode = LX_WORD;
				end
			end
			default: begin
				if (eol) begin
					emit(8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
					lex_mode = LX_IDLE;
				end
			end
		endcase
		if (step_res.size() > 0) begin
			r = step_res.pop_back();
			r.last = 1'b1;
			step_res.push_back(r);
		end
		foreach (step_res[i]) tok_expect_q.push_back(step_res[i]);
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// outputs first: a result leaving at this edge never belongs to the request taken now
	always @(posedge clk or negedge arst_n) begin : watch
		tok_result_t want;
		if (!arst_n) begin
			tok_expect_q.delete();
			lex_mode        = LX_IDLE;
			fail_count      = 0;
			pending         = 0;
			results_checked = 0;
			lines_checked   = 0;
			errors_checked  = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (line_end) lines_checked++;
				if (error_code != ERR_NONE) errors_checked++;
				if (tok_expect_q.size() == 0) begin
					fail_count++;
					$display({"%0t: unexpected result, expected none, ",
						"got char %02h flags %b%b%b err %0d"},
						$time, out_char, char_valid, token_end, line_end, error_code);
				end else begin
					want = tok_expect_q.pop_front();
					check_field("out_char", 32'(want.ch), 32'(out_char));
					check_field("char_valid", 32'(want.valid), 32'(char_valid));
					check_field("token_end", 32'(want.tend), 32'(token_end));
					check_field("line_end", 32'(want.lend), 32'(line_end));
					check_field("error_code", 32'(want.err), 32'(error_code));
					check_field("run_last", 32'(want.last), 32'(run_last));
				end
			end
			if (in_valid && in_ready) lex_char(in_char, end_of_input);
			pending = tok_expect_q.size();
		end
	end

endmodule

[dv/tb_shell_command_tokenizer_unit.sv]
// Top-level bench for the shell command tokenizer: clock, reset, request traffic, verdict.
// Depends on shell_command_tokenizer_unit and sct_token_checker (which uses sct_pkg).
`timescale 1ns / 1ps

module tb_shell_command_tokenizer_unit;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int RX_HOLD     = 60;     // receiver hold-off, long enough to fill the queue
	localparam int IDLE_PCT    = 36;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic [7:0] in_char      = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_ready    = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_char;
	logic       char_valid;
	logic       token_end;
	logic       line_end;
	logic [1:0] error_code;
	logic       run_last;

	int fail_count;
	int pending;
	int results_checked;
	int lines_checked;
	int errors_checked;

	int tx_idle_pct = IDLE_PCT;
	int rx_idle_pct = IDLE_PCT;
	bit hold_req    = 1'b0;
	int sent_count  = 0;
	int cycle_count = 0;

	shell_command_tokenizer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.char_valid   (char_valid),
		.token_end    (token_end),
		.line_end     (line_end),
		.error_code   (error_code),
		.run_last     (run_last)
	);

	sct_token_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_char         (in_char),
		.end_of_input    (end_of_input),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_char        (out_char),
		.char_valid      (char_valid),
		.token_end       (token_end),
		.line_end        (line_end),
		.error_code      (error_code),
		.run_last        (run_last),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.lines_checked   (lines_checked),
		.errors_checked  (errors_checked)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: far above the slowest legal run (two results per request, random stalls).
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver. out_ready is redrawn every falling edge; a hold request from the
	// stimulus forces a long run of ready low, counted here, so the lexer's
	// result queue fills and in_ready drops.
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = RX_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// One request. Each falling edge gets exactly one drive of in_valid: either an
	// idle cycle (valid low) or the new character, which then holds until taken.
	task automatic send_char(input logic [7:0] c, input logic eoi);
		@(negedge clk);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		in_char      <= c;
		end_of_input <= eoi;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	// Drop valid after the last request of a stretch, before waiting on anything.
	task automatic tx_rest();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
	endtask

	function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] v;
		do v = 8'($urandom_range(255)); while (v == a || v == b);
		return v;
	endfunction

	// One command line. Mostly well-formed pieces (words, quoted stretches,
	// escapes, operators, blanks, a trailing comment) with random content; a
	// small share of escapes and quotes is left broken, and noisy lines are raw
	// bytes with end of input sprinkled in.
	task automatic gen_line(input bit noisy);
		string      word_chars;
		string      op_chars;
		int         pieces;
		int         r;
		bit         done;
		logic [7:0] c;
		word_chars = "abcdefghijklmnopqrstuvwxyz0123456789-_./=$";
		op_chars   = ";()<|&>";
		if (noisy) begin
			repeat ($urandom_range(1, 10))
				send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
			return;
		end
		pieces = $urandom_range(1, 7);
		done   = 1'b0;
		for (int k = 0; k < pieces && !done; k++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				repeat ($urandom_range(1, 4))
					send_char(word_chars[$urandom_range(word_chars.len() - 1)], 1'b0);
			end else if (r < 42) begin
				// quoted stretch, possibly empty; everything inside is literal
				send_char("\"", 1'b0);
				repeat ($urandom_range(0, 4)) send_char(rand_byte_except("\"", "\n"), 1'b0);
				if ($urandom_range(9) != 0) send_char("\"", 1'b0);
				else done = 1'b1;    // left open: line end reports unclosed quote
			end else if (r < 52) begin
				send_char("\\", 1'b0);
				if ($urandom_range(9) != 0) begin
					send_char(rand_byte_except("\n", "#"), 1'b0);
				end else if ($urandom_range(1) != 0) begin
					send_char("#", 1'b0);    // bad escape; rest is lexed as a new line
				end else begin
					done = 1'b1;             // bad escape at line end
				end
			end else if (r < 72) begin
				c = op_chars[$urandom_range(op_chars.len() - 1)];
				send_char(c, 1'b0);
				if ((c == "|" || c == "&" || c == ">") && $urandom_range(1) != 0)
					send_char(c, 1'b0);
			end else if (r < 92) begin
				repeat ($urandom_range(1, 2)) send_char($urandom_range(1) ? " " : "\t", 1'b0);
			end else begin
				send_char("#", 1'b0);
				repeat ($urandom_range(0, 3)) send_char(rand_byte_except("\n", "\n"), 1'b0);
				done = 1'b1;
			end
		end
		// terminator: newline, or end of input with a junk byte that must be ignored
		if ($urandom_range(4) == 0) send_char(8'($urandom_range(255)), 1'b1);
		else send_char("\n", 1'b0);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: NUL and 0xFF as word bytes, every one-char token, single and
		// doubled operators, operator closed by another token, escape in idle,
		// empty quotes inside a word, tab separator, comment up to newline.
		send_char(8'h00, 1'b0);
		send_text(";(|)||<&&>");
		send_char(8'hFF, 1'b0);
		send_text(">>\\a\"\"\t#c\n");
		// error lines: escape before '#', escape at end of input, unclosed quote
		send_text("\\#");
		send_text("\\");
		send_char(8'($urandom_range(255)), 1'b1);
		send_text("\"");
		send_char(8'($urandom_range(255)), 1'b1);

		while (sent_count < 350) gen_line($urandom_range(9) == 0);

		// receiver holds off while the sender keeps pushing at full rate
		tx_idle_pct = 0;
		hold_req    = 1'b1;
		while (sent_count < 420) gen_line(1'b0);
		tx_idle_pct = IDLE_PCT;

		// sender pauses until everything outstanding has drained
		tx_rest();
		wait (pending == 0);

		// long stretch with no idling on either side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (sent_count < 700) gen_line($urandom_range(9) == 0);
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;

		while (sent_count < 1150) gen_line($urandom_range(9) == 0);

		tx_rest();
		wait (pending == 0);
		repeat (8) @(posedge clk);

		$display("Streamed %0d characters; checked %0d token results, %0d line ends, %0d errors.",
			sent_count, results_checked, lines_checked, errors_checked);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/sct_pkg.sv
design/sct_front.sv
design/sct_queue.sv
design/sct_back.sv
design/shell_command_tokenizer_unit.sv
design/sct_checker.sv
dv/sct_token_checker.sv
dv/tb_shell_command_tokenizer_unit.sv
